[rtl/sma_pkg.sv]
// Shared types and constants of the stack machine ALU.
// No dependencies.
package sma_pkg;
    localparam int STACK_DEPTH = 64;
    localparam int VALUE_BITS  = 32;
    localparam int FRAC_BITS   = 16;
    localparam int PTR_BITS    = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_BITS   = $clog2(STACK_DEPTH);
    localparam int ELEM_BITS   = VALUE_BITS + 1;

    typedef enum logic [4:0] {
        OP_PUSH = 5'd0, OP_ADD = 5'd1, OP_SUB = 5'd2, OP_MUL = 5'd3, OP_DIV = 5'd4,
        OP_MOD = 5'd5, OP_EQ = 5'd6, OP_NE = 5'd7, OP_GT = 5'd8, OP_GE = 5'd9,
        OP_LT = 5'd10, OP_LE = 5'd11, OP_AND = 5'd12, OP_OR = 5'd13, OP_NOT = 5'd14,
        OP_POP = 5'd15, OP_DUP = 5'd16, OP_DUP2 = 5'd17, OP_SWAP12 = 5'd18,
        OP_SWAP13 = 5'd19, OP_WRITE = 5'd20
    } t_op;

    typedef enum logic [2:0] {
        ST_OK = 3'd0, ST_UNDER = 3'd1, ST_TYPE = 3'd2, ST_FULL = 3'd3,
        ST_DIV0 = 3'd4, ST_SAT = 3'd5
    } t_status;

    // controller to datapath
    typedef struct packed {
        logic load;   // capture request
        logic rd;     // read step: fetch top/second/third
        logic exec;   // execute: start arithmetic, compute writes
        logic commit; // apply writes, build result
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic busy;   // iterative unit running
    } t_stat;
endpackage

[rtl/sma_divider.sv]
// Iterative unsigned divider, one quotient bit per cycle.
// Depends on sma_pkg.
module sma_divider (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic [sma_pkg::VALUE_BITS+sma_pkg::FRAC_BITS-1:0] i_num,
    input  logic [sma_pkg::VALUE_BITS-1:0]   i_den,
    output logic                             o_busy,
    output logic [sma_pkg::VALUE_BITS+sma_pkg::FRAC_BITS-1:0] o_quo,
    output logic [sma_pkg::VALUE_BITS-1:0]   o_rem
);
    import sma_pkg::*;
    localparam int NB = VALUE_BITS + FRAC_BITS;
    localparam int CB = $clog2(NB + 1);

    logic [NB-1:0]         r_q;
    logic [VALUE_BITS:0]   r_r;
    logic [VALUE_BITS-1:0] r_d;
    logic [CB-1:0]         r_cnt;
    logic [VALUE_BITS:0]   n_sh;
    logic [VALUE_BITS:0]   n_df;

    // shift in one numerator bit, subtract when it fits
    assign n_sh = {r_r[VALUE_BITS-1:0], r_q[NB-1]};
    assign n_df = n_sh - {1'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= CB'(NB);
            r_q   <= i_num;
            r_r   <= '0;
            r_d   <= i_den;
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
            if (!n_df[VALUE_BITS]) begin
                r_r <= n_df;
                r_q <= {r_q[NB-2:0], 1'b1};
            end else begin
                r_r <= n_sh;
                r_q <= {r_q[NB-2:0], 1'b0};
            end
        end
    end
    assign o_busy = (r_cnt != '0);
    assign o_quo  = r_q;
    assign o_rem  = r_r[VALUE_BITS-1:0];
endmodule

[rtl/sma_datapath.sv]
// Stack memory, operand registers, arithmetic and result formation.
// Depends on sma_pkg and sma_divider.
module sma_datapath (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  sma_pkg::t_cmd               i_cmd,
    output sma_pkg::t_stat              o_stat,
    input  logic [4:0]                  i_mode,
    input  logic [31:0]                 i_push_value,
    input  logic                        i_push_is_text,
    output logic [31:0]                 o_out_value,
    output logic                        o_out_is_text,
    output logic [6:0]                  o_stack_depth,
    output logic [2:0]                  o_status
);
    import sma_pkg::*;
    localparam int NB = VALUE_BITS + FRAC_BITS;
    localparam logic [VALUE_BITS-1:0] VMAX = {1'b0, {(VALUE_BITS-1){1'b1}}};
    localparam logic [VALUE_BITS-1:0] VMIN = {1'b1, {(VALUE_BITS-1){1'b0}}};
    localparam logic [VALUE_BITS-1:0] ONE  =
        (FRAC_BITS >= VALUE_BITS - 1) ? VMAX : VALUE_BITS'(1) << FRAC_BITS;

    logic [ELEM_BITS-1:0] r_mem [STACK_DEPTH];
    logic [PTR_BITS-1:0]  r_sp;
    logic [4:0]           r_mode;
    logic [ELEM_BITS-1:0] r_push;
    logic [ELEM_BITS-1:0] r_e1, r_e2, r_e3; // top, second, third
    logic [1:0]           r_rdi;
    logic [2:0]           r_st;
    logic [PTR_BITS-1:0]  r_nsp;
    logic [VALUE_BITS-1:0] r_res;
    logic                 r_div, r_mod;
    logic [2*VALUE_BITS-1:0] r_prod;
    logic                 r_mul;

    // read port: registered reads of top, second and third, one after another
    logic [ADDR_BITS-1:0] n_raddr;
    logic [ELEM_BITS-1:0] r_rdata;
    always_comb begin
        unique case (r_rdi)
            2'd0:    n_raddr = ADDR_BITS'(r_sp - 1'b1);
            2'd1:    n_raddr = ADDR_BITS'(r_sp - 2'd2);
            default: n_raddr = ADDR_BITS'(r_sp - 2'd3);
        endcase
    end

    // operand magnitudes and signs
    logic signed [VALUE_BITS-1:0] a, b;
    logic na, nb_;
    logic [VALUE_BITS-1:0] ma, mb;
    assign a = r_e2[VALUE_BITS-1:0];
    assign b = r_e1[VALUE_BITS-1:0];
    assign na = a[VALUE_BITS-1];
    assign nb_ = b[VALUE_BITS-1];
    assign ma = na ? -a : a;
    assign mb = nb_ ? -b : b;

    // divider shared by div and mod
    logic d_start, d_busy;
    logic [NB-1:0] d_num, d_quo;
    logic [VALUE_BITS-1:0] d_den, d_rem;
    sma_divider u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(d_start), .i_num(d_num),
        .i_den(d_den), .o_busy(d_busy), .o_quo(d_quo), .o_rem(d_rem)
    );

    // saturating build of a signed result from sign and magnitude
    function automatic logic [VALUE_BITS:0] build(input logic neg,
                                                  input logic [NB:0] m);
        logic [NB:0] lim;
        lim = neg ? (NB+1)'({1'b1, {(VALUE_BITS-1){1'b0}}})
                  : (NB+1)'(VMAX);
        if (m > lim) return {1'b1, neg ? VMIN : VMAX};
        return {1'b0, neg ? VALUE_BITS'(-m[VALUE_BITS-1:0])
                          : m[VALUE_BITS-1:0]};
    endfunction

    logic [VALUE_BITS:0] n_add;
    logic [VALUE_BITS:0] n_fin;
    logic                n_cmp;
    logic [ELEM_BITS-1:0] n_top;

    // add/sub with saturation
    always_comb begin
        logic signed [VALUE_BITS:0] s;
        if (r_mode == OP_SUB) s = {a[VALUE_BITS-1], a} - {b[VALUE_BITS-1], b};
        else                  s = {a[VALUE_BITS-1], a} + {b[VALUE_BITS-1], b};
        if (s[VALUE_BITS] != s[VALUE_BITS-1])
            n_add = {1'b1, s[VALUE_BITS] ? VMIN : VMAX};
        else
            n_add = {1'b0, s[VALUE_BITS-1:0]};
    end

    // compares and logic
    always_comb begin
        unique case (r_mode)
            OP_EQ:   n_cmp = (a == b);
            OP_NE:   n_cmp = (a != b);
            OP_GT:   n_cmp = (a > b);
            OP_GE:   n_cmp = (a >= b);
            OP_LT:   n_cmp = (a < b);
            OP_LE:   n_cmp = (a <= b);
            OP_AND:  n_cmp = (a != 0) && (b != 0);
            default: n_cmp = (a != 0) || (b != 0);
        endcase
    end

    // execute decisions: status, new depth, plain result and first write
    logic [2:0]            n_xst;
    logic [PTR_BITS-1:0]   n_xsp;
    logic [VALUE_BITS-1:0] n_xres;
    logic                  n_xmul, n_xdiv, n_xmod, n_we;
    logic [ADDR_BITS-1:0]  n_wa;
    logic [ELEM_BITS-1:0]  n_wd;
    always_comb begin
        n_xst  = ST_OK;
        n_xsp  = r_sp;
        n_xres = '0;
        n_xmul = 1'b0;
        n_xdiv = 1'b0;
        n_xmod = 1'b0;
        n_we   = 1'b0;
        n_wa   = ADDR_BITS'(r_sp);
        n_wd   = r_push;
        priority case (1'b1)
            (r_mode == OP_PUSH): begin
                if (r_sp >= PTR_BITS'(STACK_DEPTH)) n_xst = ST_FULL;
                else begin
                    n_we  = 1'b1;
                    n_xsp = r_sp + 1'b1;
                end
            end
            (r_mode >= OP_ADD && r_mode <= OP_AND) ||
            (r_mode == OP_OR): begin
                if (r_sp < 2) n_xst = ST_UNDER;
                else if (r_e1[VALUE_BITS]) begin
                    n_xst = ST_TYPE; n_xsp = r_sp - 1'b1;
                end else if (r_e2[VALUE_BITS]) begin
                    n_xst = ST_TYPE; n_xsp = r_sp - 2'd2;
                end else begin
                    n_xsp = r_sp - 1'b1;
                    unique case (r_mode)
                        OP_ADD, OP_SUB: begin
                            n_xres = n_add[VALUE_BITS-1:0];
                            if (n_add[VALUE_BITS]) n_xst = ST_SAT;
                        end
                        OP_MUL: n_xmul = 1'b1;
                        OP_DIV: begin
                            if (b == 0) begin
                                n_xst  = ST_DIV0;
                                n_xres = na ? VMIN : (a != 0 ? VMAX : '0);
                            end else n_xdiv = 1'b1;
                        end
                        OP_MOD: begin
                            if ((mb >> FRAC_BITS) == 0) n_xst = ST_DIV0;
                            else n_xmod = 1'b1;
                        end
                        default: n_xres = n_cmp ? ONE : '0;
                    endcase
                end
            end
            (r_mode == OP_NOT): begin
                if (r_sp < 1) n_xst = ST_UNDER;
                else if (r_e1[VALUE_BITS]) begin
                    n_xst = ST_TYPE; n_xsp = r_sp - 1'b1;
                end else begin
                    n_we = 1'b1;
                    n_wa = ADDR_BITS'(r_sp - 1'b1);
                    n_wd = {1'b0, (b == 0) ? ONE : '0};
                end
            end
            (r_mode == OP_POP) || (r_mode == OP_WRITE): begin
                if (r_sp < 1) n_xst = ST_UNDER;
                else n_xsp = r_sp - 1'b1;
            end
            (r_mode == OP_DUP): begin
                if (r_sp < 1) n_xst = ST_UNDER;
                else if (r_sp >= PTR_BITS'(STACK_DEPTH)) n_xst = ST_FULL;
                else begin
                    n_we  = 1'b1;
                    n_wd  = r_e1;
                    n_xsp = r_sp + 1'b1;
                end
            end
            (r_mode == OP_DUP2): begin
                if (r_sp < 2) n_xst = ST_UNDER;
                else if (r_sp + 2'd2 > PTR_BITS'(STACK_DEPTH)) n_xst = ST_FULL;
                else begin
                    n_we  = 1'b1;
                    n_wd  = r_e2;
                    n_xsp = r_sp + 2'd2;
                end
            end
            (r_mode == OP_SWAP12): begin
                if (r_sp < 2) n_xst = ST_UNDER;
                else begin
                    n_we = 1'b1;
                    n_wa = ADDR_BITS'(r_sp - 1'b1);
                    n_wd = r_e2;
                end
            end
            (r_mode == OP_SWAP13): begin
                if (r_sp < 3) n_xst = ST_UNDER;
                else begin
                    n_we = 1'b1;
                    n_wa = ADDR_BITS'(r_sp - 1'b1);
                    n_wd = r_rdata;
                end
            end
            default: ;
        endcase
    end

    assign d_start = i_cmd.exec && !r_e1[VALUE_BITS] && !r_e2[VALUE_BITS] &&
                     (r_sp >= 2) &&
                     ((r_mode == OP_DIV && b != 0) ||
                      (r_mode == OP_MOD && (mb >> FRAC_BITS) != 0));
    assign d_num = (r_mode == OP_DIV) ? NB'({ma, {FRAC_BITS{1'b0}}})
                                      : NB'(ma >> FRAC_BITS);
    assign d_den = (r_mode == OP_DIV) ? mb : (mb >> FRAC_BITS);
    assign o_stat.busy = d_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sp <= '0;
            r_rdi <= '0;
        end else begin
            if (i_cmd.load) begin
                r_mode <= i_mode;
                r_push <= {i_push_is_text, VALUE_BITS'($signed(i_push_value))};
                r_rdi  <= '0;
            end
            if (i_cmd.rd) begin
                r_rdata <= r_mem[n_raddr];
                r_rdi   <= r_rdi + 1'b1;
                unique case (r_rdi)
                    2'd0:    ;
                    2'd1:    r_e1 <= r_rdata;
                    default: r_e2 <= r_rdata;
                endcase
            end
            if (i_cmd.exec) begin
                r_e3   <= r_rdata;
                r_prod <= ma * mb;
                r_mul  <= n_xmul;
                r_div  <= n_xdiv;
                r_mod  <= n_xmod;
                r_st   <= n_xst;
                r_nsp  <= n_xsp;
                r_res  <= n_xres;
                if (n_we) r_mem[n_wa] <= n_wd;
            end
            // second write of dup2/swaps and binary results
            if (i_cmd.commit) begin
                r_sp <= r_nsp;
                if (r_mode == OP_DUP2 && r_st == ST_OK)
                    r_mem[ADDR_BITS'(r_sp + 1'b1)] <= r_e1;
                else if (r_mode == OP_SWAP12 && r_st == ST_OK)
                    r_mem[ADDR_BITS'(r_sp - 2'd2)] <= r_e1;
                else if (r_mode == OP_SWAP13 && r_st == ST_OK)
                    r_mem[ADDR_BITS'(r_sp - 2'd3)] <= r_e1;
                else if (r_mode >= OP_ADD && r_mode <= OP_OR &&
                         r_mode != OP_NOT && r_nsp == r_sp - 1'b1 &&
                         (r_st == ST_OK || r_st == ST_SAT || r_st == ST_DIV0))
                    r_mem[ADDR_BITS'(r_sp - 2'd2)] <= {1'b0, n_fin[VALUE_BITS-1:0]};
            end
        end
    end

    // final binary value, including iterative and multiplier results
    always_comb begin
        logic neg;
        neg = na ^ nb_;
        if (r_mul)
            n_fin = build(neg, (NB+1)'(r_prod >> FRAC_BITS) |
                          ((r_prod >> FRAC_BITS) > (2*VALUE_BITS)'({(NB+1){1'b1}})
                           ? {(NB+1){1'b1}} : '0));
        else if (r_div)
            n_fin = build(neg, {1'b0, d_quo});
        else if (r_mod)
            n_fin = build(na, (NB+1)'({d_rem, {FRAC_BITS{1'b0}}}));
        else
            n_fin = {1'b0, r_res};
    end

    // shown element after the instruction
    logic [2:0] n_st;
    always_comb begin
        n_st = r_st;
        if ((r_mul || r_div || r_mod) && n_fin[VALUE_BITS]) n_st = ST_SAT;
        n_top = '0;
        if (r_mode == OP_WRITE && r_st == ST_OK) n_top = r_e1;
        else if (r_nsp != 0) begin
            if (r_st != ST_OK && r_st != ST_SAT && r_st != ST_DIV0)
                n_top = (r_nsp == r_sp) ? r_e1 :
                        (r_nsp == r_sp - 1'b1) ? r_e2 : r_e3;
            else begin
                unique case (r_mode)
                    OP_PUSH:   n_top = r_push;
                    OP_NOT:    n_top = {1'b0, (b == 0) ? ONE : '0};
                    OP_POP:    n_top = r_e2;
                    OP_DUP, OP_DUP2, OP_SWAP12, OP_SWAP13: n_top = r_e1;
                    default: begin
                        if (r_mode >= OP_ADD && r_mode <= OP_OR)
                            n_top = {1'b0, n_fin[VALUE_BITS-1:0]};
                        else n_top = r_e1;
                    end
                endcase
                if (r_mode == OP_SWAP12) n_top = r_e2;
                if (r_mode == OP_SWAP13) n_top = r_e3;
            end
        end
    end

    // result register: held until taken
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            o_out_value   <= n_top[31:0];
            o_out_is_text <= n_top[VALUE_BITS];
            o_stack_depth <= 7'(r_nsp);
            o_status      <= n_st;
        end
    end
endmodule

[rtl/sma_ctrl.sv]
// Sequencer of one instruction: capture, read, execute, wait, commit, deliver.
// Depends on sma_pkg.
module sma_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output sma_pkg::t_cmd  o_cmd,
    input  sma_pkg::t_stat i_stat
);
    import sma_pkg::*;
    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001, S_RD0 = 7'b0000010, S_RD1 = 7'b0000100,
        S_RD2 = 7'b0001000, S_EXEC = 7'b0010000, S_WAIT = 7'b0100000,
        S_OUT = 7'b1000000
    } t_state;
    t_state r_state, n_state;
    logic   r_ov;

    assign o_in_ready = (r_state == S_IDLE);
    assign o_out_valid = r_ov;
    assign o_cmd.load = o_in_ready && i_in_valid;
    assign o_cmd.rd   = (r_state == S_RD0) || (r_state == S_RD1) || (r_state == S_RD2);
    assign o_cmd.exec = (r_state == S_EXEC);
    assign o_cmd.commit = (r_state == S_WAIT) && !i_stat.busy && !(r_ov && !i_out_ready);

    // advance the sequence
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_in_valid) n_state = S_RD0;
            S_RD0:  n_state = S_RD1;
            S_RD1:  n_state = S_RD2;
            S_RD2:  n_state = S_EXEC;
            S_EXEC: n_state = S_WAIT;
            S_WAIT: if (o_cmd.commit) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.commit) r_ov <= 1'b1;
            else if (i_out_ready) r_ov <= 1'b0;
        end
    end
endmodule

[rtl/stack_machine_alu.sv]
// Top level of the stack machine ALU: controller plus datapath.
// Depends on sma_pkg, sma_ctrl, sma_datapath.
//
//  channel | direction | tdata (low bit up)                  | tuser
//  s_axis  | in        | mode[4:0], push_value[36:5]         | push_is_text
//  m_axis  | out       | out_value[31:0], depth[38:32], status[41:39], pad | out_is_text
//
// Stack shuffles and simple math run capture, three memory reads over one
// read port, execute and commit; div and mod also wait for the
// shift-subtract divider. The result register frees the sequencer unless
// an older result is still waiting. Reset is synchronous; in the datapath
// it clears the stack pointer and read index, not the stack entries.
module stack_machine_alu (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,  // mode, push_value
    input  logic        s_axis_tuser,  // push_is_text
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,  // out_value, stack_depth, status
    output logic        m_axis_tuser   // out_is_text
);
    import sma_pkg::*;
    t_cmd  w_cmd;
    t_stat w_stat;
    logic [31:0] w_val;
    logic [6:0]  w_dep;
    logic [2:0]  w_st;

    sma_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(s_axis_tvalid),
        .o_in_ready(s_axis_tready), .o_out_valid(m_axis_tvalid),
        .i_out_ready(m_axis_tready), .o_cmd(w_cmd), .i_stat(w_stat)
    );
    sma_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(w_cmd), .o_stat(w_stat),
        .i_mode(s_axis_tdata[4:0]), .i_push_value(s_axis_tdata[36:5]),
        .i_push_is_text(s_axis_tuser), .o_out_value(w_val),
        .o_out_is_text(m_axis_tuser), .o_stack_depth(w_dep), .o_status(w_st)
    );
    assign m_axis_tdata = {6'd0, w_st, w_dep, w_val};

    // a result never appears without a commit
    a_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(w_cmd.commit)) else $error("valid w/o commit");
    // no request taken while busy
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stat.busy |-> !s_axis_tready) else $error("ready while dividing");
endmodule
